### hw/rtl/integer_to_text_formatter_assert.svh
// Assertion macros for the integer-to-text formatter.
// Used by the top level; needs a clock and an active-low reset name.
`ifndef INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH
`define INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH

// same-cycle implication, off during reset
`define IFT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define IFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ift_pkg.sv
// Package for the integer-to-text formatter: sizes, character codes,
// state encodings, divider status type and the digit-to-ASCII function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ift_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int DIGIT_SLOTS = 32;
  localparam int MAX_FIELD   = 60;

  localparam int RADIX_W = 6;
  localparam int FIELD_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;
  // character counts: up to 60 digits plus sign and prefix
  localparam int CNT_W   = 7;
  localparam int RESULT_CAP = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_BAD   = 5'b10000
  } state_e;

  typedef enum logic [5:0] {
    SEG_LEAD  = 6'b000001,
    SEG_SIGN  = 6'b000010,
    SEG_PFX   = 6'b000100,
    SEG_ZERO  = 6'b001000,
    SEG_DIG   = 6'b010000,
    SEG_TRAIL = 6'b100000
  } seg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dx;
    dx = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = (upper ? CH_UC_A : CH_LC_A) + dx - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ift_div.sv
// Shared restoring divider: one quotient bit per cycle, small divisor.
// Gives quotient and remainder with a one-cycle done pulse once all VALUE_BITS quotient bits are in.
// Depends on ift_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ift_div #(
  parameter int VALUE_BITS = ift_pkg::VALUE_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [VALUE_BITS-1:0]           dividend_i,
  input  wire logic [ift_pkg::RADIX_W-1:0]     divisor_i,
  output ift_pkg::div_stat_t                   stat_o,
  output logic      [VALUE_BITS-1:0]           quot_o,
  output logic      [ift_pkg::DIGIT_W-1:0]     rem_o
);

  localparam int BW = $clog2(VALUE_BITS + 1);

  logic                            busy_q, done_q;
  logic [BW-1:0]                   bit_q;
  logic [VALUE_BITS-1:0]           work_q;
  logic [ift_pkg::DIGIT_W-1:0]     rem_q;
  logic [ift_pkg::RADIX_W-1:0]     div_q;
  logic [ift_pkg::DIGIT_W:0]       trial, diff;
  logic                            ge;

  always_comb begin
    trial = {rem_q, work_q[VALUE_BITS-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      bit_q  <= BW'(VALUE_BITS);
    end else if (busy_q) begin
      bit_q <= bit_q - BW'(1);
      if (bit_q == BW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= {work_q[VALUE_BITS-2:0], ge};
      rem_q  <= ge ? diff[ift_pkg::DIGIT_W-1:0] : trial[ift_pkg::DIGIT_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = work_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

### hw/rtl/integer_to_text_formatter.sv
// Channel | dir | beat
// in      | in  | value, radix, min_width, min_digits, format flags
// out     | out | one ASCII character, last, bad_radix
//
// Flow: the D digits (D is the length of the magnitude in the radix, at least 1) come one
// by one from the shared bit-serial divider, then a setup state, then one character per
// cycle while out is not stalled, with a pause at each of up to five segment switches.
// A bad radix goes through ST_BAD to one error beat. Ready only while idle; stalls on out hold emission.
// Reset clears control only; the digit store needs no clearing pass.
// Top level; depends on ift_pkg, ift_div and integer_to_text_formatter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_text_formatter_assert.svh"

module integer_to_text_formatter #(
  parameter int VALUE_BITS  = ift_pkg::VALUE_BITS,
  parameter int DIGIT_SLOTS = ift_pkg::DIGIT_SLOTS,
  parameter int MAX_FIELD   = ift_pkg::MAX_FIELD
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [31:0]                   value_i,
  input  wire logic [ift_pkg::RADIX_W-1:0]   radix_i,
  input  wire logic [ift_pkg::FIELD_W-1:0]   min_width_i,
  input  wire logic [ift_pkg::FIELD_W-1:0]   min_digits_i,
  input  wire logic                          zero_pad_i,
  input  wire logic                          is_signed_i,
  input  wire logic                          plus_sign_i,
  input  wire logic                          space_sign_i,
  input  wire logic                          left_justify_i,
  input  wire logic                          alt_prefix_i,
  input  wire logic                          upper_case_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [ift_pkg::CHAR_W-1:0]    character_o,
  output logic                               last_o,
  output logic                               bad_radix_o
);

  localparam int IDX_W = $clog2(DIGIT_SLOTS);
  localparam int NDC_W = $clog2(DIGIT_SLOTS + 1);
  localparam int CNT_W = ift_pkg::CNT_W;
  localparam int FW    = ift_pkg::FIELD_W;
  localparam int CW    = ift_pkg::CHAR_W;

  ift_pkg::state_e state_q, state_d;
  ift_pkg::seg_e   seg_q, seg_d;

  logic [CNT_W-1:0]              cnt_q, cnt_d, tot_q, tot_d;
  logic [NDC_W-1:0]              count_q, count_d;
  logic [IDX_W-1:0]              rd_idx_q, rd_idx_d;
  logic [ift_pkg::DIGIT_W-1:0]   digit_store_q [DIGIT_SLOTS];
  logic [ift_pkg::DIGIT_W-1:0]   rd_q;

  // latched item
  logic [ift_pkg::RADIX_W-1:0]   radix_q;
  logic [FW-1:0]                 wsat_q, psat_q;
  logic                          left_q, zpad_q, upper_q, sign_len_q;
  logic [1:0]                    pfx_len_q;
  logic [CW-1:0]                 sign_ch_q;
  logic [CNT_W-1:0]              zero_q, trail_q;

  // output register
  logic                          out_valid_q, out_valid_d, out_load;
  logic [CW-1:0]                 char_q, char_d;
  logic                          last_q, last_d, bad_q, bad_d;
  logic                          out_free;

  // divider
  ift_pkg::div_stat_t            div_stat;
  logic                          div_start;
  logic [VALUE_BITS-1:0]         div_dividend, div_quot;
  logic [ift_pkg::RADIX_W-1:0]   div_divisor;
  logic [ift_pkg::DIGIT_W-1:0]   div_rem;

  // input decode
  logic                          in_acc, radix_bad, neg;
  logic [63:0]                   val64;
  logic [VALUE_BITS-1:0]         val_v, mag;
  logic [FW-1:0]                 wsat_in, psat_in;

  // setup math
  logic [CNT_W-1:0]              nd, p_ext, w_ext, p_eff, overhead, pad, tot_full;
  logic                          mem_we;

  assign in_ready_o = (state_q == ift_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    val64     = {32'b0, value_i};
    val_v     = val64[VALUE_BITS-1:0];
    neg       = is_signed_i && val_v[VALUE_BITS-1];
    mag       = neg ? (~val_v + VALUE_BITS'(1)) : val_v;
    radix_bad = (radix_i < ift_pkg::RADIX_MIN) || (radix_i > ift_pkg::RADIX_MAX);
    wsat_in   = (min_width_i > FW'(MAX_FIELD)) ? FW'(MAX_FIELD) : min_width_i;
    psat_in   = (min_digits_i > FW'(MAX_FIELD)) ? FW'(MAX_FIELD) : min_digits_i;
  end

  always_comb begin
    nd       = CNT_W'(count_q);
    p_ext    = CNT_W'(psat_q);
    w_ext    = CNT_W'(wsat_q);
    p_eff    = (p_ext > nd) ? p_ext : nd;
    overhead = p_eff + CNT_W'(sign_len_q) + CNT_W'(pfx_len_q);
    pad      = (w_ext > overhead) ? (w_ext - overhead) : '0;
    tot_full = pad + overhead;
  end

  assign div_start    = (in_acc && !radix_bad) ||
                        ((state_q == ift_pkg::ST_DIV) && div_stat.done &&
                         (div_quot != '0));
  assign div_dividend = in_ready_o ? mag : div_quot;
  assign div_divisor  = in_ready_o ? radix_i : radix_q;
  assign mem_we       = (state_q == ift_pkg::ST_DIV) && div_stat.done &&
                        (count_q < NDC_W'(DIGIT_SLOTS));

  ift_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    cnt_d       = cnt_q;
    tot_d       = tot_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    out_load    = 1'b0;
    char_d      = char_q;
    last_d      = last_q;
    bad_d       = bad_q;

    case (state_q)
      ift_pkg::ST_IDLE: begin
        if (in_acc) begin
          count_d = '0;
          state_d = radix_bad ? ift_pkg::ST_BAD : ift_pkg::ST_DIV;
        end
      end
      ift_pkg::ST_BAD: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = ift_pkg::CH_NUL;
          last_d   = 1'b1;
          bad_d    = 1'b1;
          state_d  = ift_pkg::ST_IDLE;
        end
      end
      ift_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (mem_we) count_d = count_q + NDC_W'(1);
          if (div_quot == '0) state_d = ift_pkg::ST_SETUP;
        end
      end
      ift_pkg::ST_SETUP: begin
        seg_d    = ift_pkg::SEG_LEAD;
        cnt_d    = (!zpad_q && !left_q) ? pad : '0;
        tot_d    = (tot_full > CNT_W'(ift_pkg::RESULT_CAP)) ?
                   CNT_W'(ift_pkg::RESULT_CAP) : tot_full;
        rd_idx_d = IDX_W'(count_q - NDC_W'(1));
        state_d  = ift_pkg::ST_EMIT;
      end
      ift_pkg::ST_EMIT: begin
        if (cnt_q == '0) begin
          // segment done: move on and load the next length
          case (seg_q)
            ift_pkg::SEG_LEAD: begin
              seg_d = ift_pkg::SEG_SIGN;
              cnt_d = CNT_W'(sign_len_q);
            end
            ift_pkg::SEG_SIGN: begin
              seg_d = ift_pkg::SEG_PFX;
              cnt_d = CNT_W'(pfx_len_q);
            end
            ift_pkg::SEG_PFX: begin
              seg_d = ift_pkg::SEG_ZERO;
              cnt_d = zero_q;
            end
            ift_pkg::SEG_ZERO: begin
              seg_d = ift_pkg::SEG_DIG;
              cnt_d = nd;
            end
            ift_pkg::SEG_DIG: begin
              seg_d = ift_pkg::SEG_TRAIL;
              cnt_d = trail_q;
            end
            default: begin
              seg_d = ift_pkg::SEG_TRAIL;
              cnt_d = '0;
            end
          endcase
        end else if (out_free) begin
          out_load = 1'b1;
          last_d   = (tot_q == CNT_W'(1));
          bad_d    = 1'b0;
          cnt_d    = cnt_q - CNT_W'(1);
          tot_d    = tot_q - CNT_W'(1);
          case (seg_q)
            ift_pkg::SEG_SIGN: char_d = sign_ch_q;
            ift_pkg::SEG_PFX: begin
              char_d = ((pfx_len_q == 2'd2) && (cnt_q == CNT_W'(1))) ?
                       (upper_q ? ift_pkg::CH_UC_X : ift_pkg::CH_LC_X) :
                       ift_pkg::CH_ZERO;
            end
            ift_pkg::SEG_ZERO: char_d = ift_pkg::CH_ZERO;
            ift_pkg::SEG_DIG: begin
              char_d   = ift_pkg::digit_char(rd_q, upper_q);
              rd_idx_d = rd_idx_q - IDX_W'(1);
            end
            default: char_d = ift_pkg::CH_SPACE;
          endcase
          if (tot_q == CNT_W'(1)) state_d = ift_pkg::ST_IDLE;
        end
      end
      default: state_d = ift_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ift_pkg::ST_IDLE;
      seg_q       <= ift_pkg::SEG_LEAD;
      cnt_q       <= '0;
      tot_q       <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      cnt_q       <= cnt_d;
      tot_q       <= tot_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    bad_q  <= bad_d;
    if (in_acc) begin
      radix_q    <= radix_i;
      wsat_q     <= wsat_in;
      psat_q     <= psat_in;
      left_q     <= left_justify_i;
      zpad_q     <= zero_pad_i && !left_justify_i;
      upper_q    <= upper_case_i;
      sign_len_q <= neg || (is_signed_i && (plus_sign_i || space_sign_i));
      sign_ch_q  <= neg ? ift_pkg::CH_MINUS :
                    (plus_sign_i ? ift_pkg::CH_PLUS : ift_pkg::CH_SPACE);
      pfx_len_q  <= !alt_prefix_i ? 2'd0 :
                    (radix_i == ift_pkg::RADIX_HEX) ? 2'd2 :
                    (radix_i == ift_pkg::RADIX_OCT) ? 2'd1 : 2'd0;
    end
    if (state_q == ift_pkg::ST_SETUP) begin
      zero_q  <= (zpad_q ? pad : '0) + (p_eff - nd);
      trail_q <= left_q ? pad : '0;
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (mem_we) digit_store_q[count_q[IDX_W-1:0]] <= div_rem;
    rd_q <= digit_store_q[rd_idx_d];
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign bad_radix_o = bad_q;

  `IFT_ASSERT_IMPLIES(a_div_done_in_div, clk_i, rst_ni, div_stat.done, state_q == ift_pkg::ST_DIV, "divider finished outside digit phase")
  `IFT_ASSERT_IMPLIES(a_idle_div_quiet, clk_i, rst_ni, in_ready_o, !div_stat.busy, "divider busy while idle")
  `IFT_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_acc, !in_ready_o, "ready right after input beat")
  `IFT_ASSERT_IMPLIES(a_bad_single, clk_i, rst_ni, out_valid_o && bad_radix_o, last_o && (character_o == ift_pkg::CH_NUL), "error beat malformed")

endmodule

`default_nettype wire

### sim/tb_integer_to_text_formatter.sv
// Self-checking testbench for integer_to_text_formatter: drives numbers with random
// radix, width, precision and flags, predicts the printf-style text per character.
// Depends on ift_pkg and the formatter RTL.
`timescale 1ns / 1ps

module tb_integer_to_text_formatter;

  localparam int RW = ift_pkg::RADIX_W;
  localparam int FW = ift_pkg::FIELD_W;
  localparam int CW = ift_pkg::CHAR_W;
  localparam int DW = ift_pkg::DIGIT_W;

  localparam int RANDOM_ITEMS  = 300;
  localparam int IDLE_PCT      = 34;
  localparam int HOLD_CYCLES   = 1500;
  localparam int WATCHDOG_MAX  = 8000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int REPORT_MAX    = 20;

  // flag masks for building requests
  localparam bit [6:0] F_NONE   = 7'h00;
  localparam bit [6:0] F_ZERO   = 7'h01;
  localparam bit [6:0] F_SIGNED = 7'h02;
  localparam bit [6:0] F_PLUS   = 7'h04;
  localparam bit [6:0] F_SPACE  = 7'h08;
  localparam bit [6:0] F_LEFT   = 7'h10;
  localparam bit [6:0] F_ALT    = 7'h20;
  localparam bit [6:0] F_UPPER  = 7'h40;

  typedef struct {
    bit [31:0]   value;
    bit [RW-1:0] radix;
    bit [FW-1:0] min_width;
    bit [FW-1:0] min_digits;
    bit          zero_pad;
    bit          is_signed;
    bit          plus_sign;
    bit          space_sign;
    bit          left_justify;
    bit          alt_prefix;
    bit          upper_case;
  } fmt_req_t;

  typedef struct {
    bit [CW-1:0] character;
    bit          last;
    bit          bad_radix;
  } text_beat_t;

  class text_scoreboard;
    text_beat_t  pending[$];
    bit [DW-1:0] digit_mem[ift_pkg::DIGIT_SLOTS];
    int unsigned digit_total;
    int unsigned errors, numbers, chars_seen, bad_seen, reports;
    string lower_glyphs = "0123456789abcdefghijklmnopqrstuvwxyz";
    string upper_glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    // expand one accepted number into its characters
    function void note_request(fmt_req_t r);
      byte unsigned text[$];
      text_beat_t   b;
      bit [31:0]    mag;
      bit [CW-1:0]  sign_ch;
      int width, prec, size, nd, k;
      bit left, zpad;
      string glyphs;
      numbers++;
      if (r.radix < ift_pkg::RADIX_MIN || r.radix > ift_pkg::RADIX_MAX) begin
        b.character = ift_pkg::CH_NUL;
        b.last = 1'b1;
        b.bad_radix = 1'b1;
        pending.push_back(b);
        bad_seen++;
        return;
      end
      glyphs = r.upper_case ? upper_glyphs : lower_glyphs;
      left = r.left_justify;
      zpad = r.zero_pad && !left;
      width = (r.min_width > ift_pkg::MAX_FIELD) ? ift_pkg::MAX_FIELD : r.min_width;
      prec = (r.min_digits > ift_pkg::MAX_FIELD) ? ift_pkg::MAX_FIELD : r.min_digits;
      size = width;
      mag = r.value;
      sign_ch = ift_pkg::CH_NUL;
      if (r.is_signed) begin
        if (mag[31]) begin
          sign_ch = ift_pkg::CH_MINUS;
          mag = -mag;
          size--;
        end else if (r.plus_sign) begin
          sign_ch = ift_pkg::CH_PLUS;
          size--;
        end else if (r.space_sign) begin
          sign_ch = ift_pkg::CH_SPACE;
          size--;
        end
      end
      if (r.alt_prefix) begin
        if (r.radix == ift_pkg::RADIX_HEX) size -= 2;
        else if (r.radix == ift_pkg::RADIX_OCT) size--;
      end
      digit_total = 0;
      if (mag == 0) begin
        digit_mem[0] = '0;
        digit_total = 1;
      end else begin
        while (mag != 0) begin
          if (digit_total < ift_pkg::DIGIT_SLOTS) begin
            digit_mem[digit_total] = DW'(mag % r.radix);
            digit_total++;
          end
          mag = mag / r.radix;
        end
      end
      nd = digit_total;
      if (nd > prec) prec = nd;
      size -= prec;
      if (!zpad && !left)
        for (; size > 0; size--) text.push_back(ift_pkg::CH_SPACE);
      if (sign_ch != ift_pkg::CH_NUL) text.push_back(sign_ch);
      if (r.alt_prefix) begin
        if (r.radix == ift_pkg::RADIX_OCT) begin
          text.push_back(ift_pkg::CH_ZERO);
        end else if (r.radix == ift_pkg::RADIX_HEX) begin
          text.push_back(ift_pkg::CH_ZERO);
          text.push_back(glyphs[33]);
        end
      end
      if (!left)
        for (; size > 0; size--) text.push_back(ift_pkg::CH_ZERO);
      for (k = nd; k < prec; k++) text.push_back(ift_pkg::CH_ZERO);
      for (k = nd - 1; k >= 0; k--) text.push_back(glyphs[digit_mem[k] % 36]);
      for (; size > 0; size--) text.push_back(ift_pkg::CH_SPACE);
      // text never exceeds the 64-character cap with these sizes
      for (k = 0; k < text.size() && k < ift_pkg::RESULT_CAP; k++) begin
        b.character = text[k];
        b.last = (k == text.size() - 1) || (k == ift_pkg::RESULT_CAP - 1);
        b.bad_radix = 1'b0;
        pending.push_back(b);
      end
    endfunction

    function void check_beat(bit [CW-1:0] ch, bit last, bit bad);
      text_beat_t want;
      chars_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (reports++ < REPORT_MAX)
          $display("%0t: unexpected beat: expected none, actual char %h last %b bad_radix %b",
                   $time, ch, last, bad);
        return;
      end
      want = pending.pop_front();
      if (want.character != ch || want.last != last || want.bad_radix != bad) begin
        errors++;
        if (reports++ < REPORT_MAX)
          $display({"%0t: mismatch: expected char %h last %b bad_radix %b, ",
                    "actual char %h last %b bad_radix %b"},
                   $time, want.character, want.last, want.bad_radix, ch, last, bad);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] value_i = '0;
  logic [RW-1:0] radix_i = '0;
  logic [FW-1:0] min_width_i = '0;
  logic [FW-1:0] min_digits_i = '0;
  logic zero_pad_i = 1'b0;
  logic is_signed_i = 1'b0;
  logic plus_sign_i = 1'b0;
  logic space_sign_i = 1'b0;
  logic left_justify_i = 1'b0;
  logic alt_prefix_i = 1'b0;
  logic upper_case_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CW-1:0] character_o;
  logic last_o;
  logic bad_radix_o;

  text_scoreboard sb = new();
  bit calm = 1'b0;          // no idling on either side while set
  bit hold_armed = 1'b0;    // receiver takes one long hold-off when set
  int unsigned quiet_cycles = 0;

  integer_to_text_formatter dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .value_i, .radix_i, .min_width_i, .min_digits_i,
    .zero_pad_i, .is_signed_i, .plus_sign_i, .space_sign_i,
    .left_justify_i, .alt_prefix_i, .upper_case_i,
    .out_valid_o, .out_ready_i,
    .character_o, .last_o, .bad_radix_o
  );

  always #5 clk_i = ~clk_i;

  function automatic fmt_req_t make_req(bit [31:0] v, bit [RW-1:0] rdx,
                                        bit [FW-1:0] fw, bit [FW-1:0] md,
                                        bit [6:0] flags);
    fmt_req_t r;
    r.value = v;
    r.radix = rdx;
    r.min_width = fw;
    r.min_digits = md;
    r.zero_pad = |(flags & F_ZERO);
    r.is_signed = |(flags & F_SIGNED);
    r.plus_sign = |(flags & F_PLUS);
    r.space_sign = |(flags & F_SPACE);
    r.left_justify = |(flags & F_LEFT);
    r.alt_prefix = |(flags & F_ALT);
    r.upper_case = |(flags & F_UPPER);
    return r;
  endfunction

  function automatic fmt_req_t random_req();
    bit [31:0] v;
    bit [RW-1:0] rdx;
    bit [FW-1:0] fw, md;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) rdx = RW'($urandom_range(1) ? $urandom_range(1) : $urandom_range(63, 37));
    else if (pick < 18) rdx = ift_pkg::RADIX_HEX;
    else if (pick < 26) rdx = ift_pkg::RADIX_OCT;
    else if (pick < 34) rdx = 6'd10;
    else rdx = RW'($urandom_range(36, 2));
    pick = $urandom_range(99);
    if (pick < 10) v = '0;
    else if (pick < 15) v = 32'h8000_0000;
    else if (pick < 20) v = 32'hFFFF_FFFF;
    else if (pick < 40) v = $urandom_range(255);
    else v = $urandom;
    // mostly short fields, now and then past the saturation point
    fw = FW'(($urandom_range(99) < 75) ? $urandom_range(12) : $urandom_range(63));
    md = FW'(($urandom_range(99) < 75) ? $urandom_range(12) : $urandom_range(63));
    return make_req(v, rdx, fw, md, 7'($urandom_range(127)));
  endfunction

  task automatic send_item(fmt_req_t r);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_valid_i <= 1'b1;
    value_i <= r.value;
    radix_i <= r.radix;
    min_width_i <= r.min_width;
    min_digits_i <= r.min_digits;
    zero_pad_i <= r.zero_pad;
    is_signed_i <= r.is_signed;
    plus_sign_i <= r.plus_sign;
    space_sign_i <= r.space_sign;
    left_justify_i <= r.left_justify;
    alt_prefix_i <= r.alt_prefix;
    upper_case_i <= r.upper_case;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat(character_o, last_o, bad_radix_o);
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("[integer_to_text_formatter] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero value, alternate prefix on zero and on a radix without prefix
    send_item(make_req(32'd0, 6'd10, 6'd0, 6'd0, F_NONE));
    send_item(make_req(32'd0, ift_pkg::RADIX_OCT, 6'd0, 6'd0, F_ALT));
    send_item(make_req(32'd0, ift_pkg::RADIX_HEX, 6'd0, 6'd0, F_ALT));
    send_item(make_req(32'd0, 6'd10, 6'd0, 6'd0, F_ALT | F_UPPER));
    send_item(make_req(32'd0, 6'd2, 6'd0, 6'd0, 7'h7F & ~F_LEFT));
    // widest digit strings and the most negative number
    send_item(make_req(32'hFFFF_FFFF, ift_pkg::RADIX_MIN, 6'd0, 6'd0, F_NONE));
    send_item(make_req(32'h8000_0000, 6'd10, 6'd0, 6'd0, F_SIGNED));
    send_item(make_req(32'h8000_0000, ift_pkg::RADIX_MIN, 6'd63, 6'd0, F_SIGNED | F_ZERO));
    send_item(make_req(32'hFFFF_FFFF, ift_pkg::RADIX_HEX, 6'd0, 6'd0, F_SIGNED));
    // sign flags, with and without is_signed
    send_item(make_req(32'h7FFF_FFFF, 6'd10, 6'd20, 6'd0, F_SIGNED | F_PLUS));
    send_item(make_req(32'd123, 6'd10, 6'd6, 6'd0, F_SIGNED | F_SPACE));
    send_item(make_req(32'd123, 6'd10, 6'd6, 6'd0, F_PLUS | F_SPACE));
    // padding: zeros, left justify overriding zeros, saturation
    send_item(make_req(32'd255, ift_pkg::RADIX_HEX, 6'd10, 6'd0, F_ALT | F_UPPER | F_ZERO));
    send_item(make_req(32'd255, ift_pkg::RADIX_HEX, 6'd10, 6'd0, F_ALT | F_LEFT | F_ZERO));
    send_item(make_req(32'd8, ift_pkg::RADIX_OCT, 6'd60, 6'd63, F_ALT));
    send_item(make_req(32'd5, 6'd3, 6'd63, 6'd63, F_SIGNED | F_PLUS | F_ALT));
    send_item(make_req(32'd1, ift_pkg::RADIX_MAX, 6'd5, 6'd0, F_LEFT));
    send_item(make_req(32'hDEAD_BEEF, ift_pkg::RADIX_MAX, 6'd0, 6'd0, F_UPPER));
    send_item(make_req(32'hDEAD_BEEF, ift_pkg::RADIX_MAX, 6'd0, 6'd12, F_NONE));
    send_item(make_req(32'h1234_5678, 6'd17, 6'd40, 6'd3, F_LEFT | F_SIGNED));
    // bad radix at both ends of the range
    send_item(make_req(32'hA5A5_A5A5, 6'd0, 6'd63, 6'd63, 7'h7F));
    send_item(make_req(32'h5A5A_5A5A, 6'd1, 6'd10, 6'd0, F_NONE));
    send_item(make_req(32'd7, 6'd37, 6'd0, 6'd0, F_ALT));
    send_item(make_req(32'hFFFF_FFFF, 6'd63, 6'd0, 6'd0, F_SIGNED));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 180 && n < 230);
      if (n == 100) hold_armed = 1'b1;
      send_item(random_req());
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d numbers, %0d with a bad radix; %0d characters checked, %0d errors",
             sb.numbers, sb.bad_seen, sb.chars_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[integer_to_text_formatter] OK");
    end else begin
      $display("[integer_to_text_formatter] ERROR");
    end
    $finish;
  end

endmodule

### integer_to_text_formatter.f
+incdir+hw/rtl
hw/rtl/ift_pkg.sv
hw/rtl/ift_div.sv
hw/rtl/integer_to_text_formatter.sv
sim/tb_integer_to_text_formatter.sv
